### design/pcg_pkg.sv
// Shared types and constants for the PCG64-DXSM bounded generator.
package pcg_pkg;

  localparam logic [63:0] DxsmMult = 64'd15750249268501108917;
  localparam logic [63:0] IncHighReset = 64'd6364136223846793005;
  localparam logic [63:0] IncLowReset = 64'd1442695040888963407;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegIncHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIncLow = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSeedHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSeedLow = 2'd3;

  typedef enum logic [1:0] {
    ACT_RAW = 2'd0,
    ACT_BOUNDED = 2'd1,
    ACT_CHOOSE = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // Multiplier operation: 32x32 partial products accumulated over cycles.
  typedef struct packed {
    logic start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_THRESH,
    ST_WAIT_THRESH,
    ST_LCG_LO,
    ST_WAIT_LCG_LO,
    ST_LCG_HI,
    ST_WAIT_LCG_HI,
    ST_PERM1,
    ST_WAIT_PERM1,
    ST_PERM2,
    ST_WAIT_PERM2,
    ST_CHECK,
    ST_MOD,
    ST_WAIT_MOD,
    ST_RESULT,
    ST_OUT1,
    ST_OUT2
  } state_t;

endpackage

### design/pcg_stream_if.sv
// Valid/ready stream interfaces for requests and results.
interface pcg_req_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [63:0] bound;
  modport source (output valid, output action, output bound, input ready);
  modport sink (input valid, input action, input bound, output ready);
endinterface

interface pcg_res_if;
  logic valid;
  logic ready;
  logic [63:0] value;
  logic last;
  logic error;
  modport source (output valid, output value, output last, output error, input ready);
  modport sink (input valid, input value, input last, input error, output ready);
endinterface

### design/pcg_mul.sv
// Iterative 64x64 multiplier: one 32x32 partial product per cycle.
module pcg_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pcg_pkg::mul_req_t  req,
  output pcg_pkg::mul_rsp_t  rsp
);

  logic [63:0] a_r, b_r;
  logic [127:0] acc_r;
  logic [2:0] step_r;
  logic busy_r, done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] pp_r;
  logic [1:0] pp_sel_r;
  logic pp_vld_r;

  always_comb begin
    op_a = step_r[1] ? a_r[63:32] : a_r[31:0];
    op_b = step_r[0] ? b_r[63:32] : b_r[31:0];
  end

  // Stage 1 registers the partial product, stage 2 accumulates it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      pp_vld_r <= 1'b0;
      if (req.start) begin
        a_r <= req.a;
        b_r <= req.b;
        acc_r <= '0;
        step_r <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r < 3'd4) begin
          pp_r <= op_a * op_b;
          pp_sel_r <= step_r[1:0];
          pp_vld_r <= 1'b1;
          step_r <= step_r + 3'd1;
        end else if (!pp_vld_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (pp_vld_r) begin
        case (pp_sel_r)
          2'd0: acc_r <= acc_r + {64'd0, pp_r};
          2'd1, 2'd2: acc_r <= acc_r + {32'd0, pp_r, 32'd0};
          default: acc_r <= acc_r + {pp_r, 64'd0};
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### design/pcg_div.sv
// Restoring divider: one quotient bit per cycle, remainder only.
module pcg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pcg_pkg::div_req_t  req,
  output pcg_pkg::div_rsp_t  rsp
);

  logic [63:0] num_r, den_r, rem_r;
  logic [6:0] cnt_r;
  logic busy_r, done_r;
  logic [64:0] trial;

  assign trial = {rem_r, num_r[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r <= req.num;
        den_r <= req.den;
        rem_r <= '0;
        cnt_r <= 7'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // Shift in one numerator bit, subtract where it fits.
        if (!trial[64]) rem_r <= trial[63:0];
        else rem_r <= {rem_r[62:0], num_r[63]};
        num_r <= {num_r[62:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem = rem_r;

endmodule

### design/pcg64_dxsm_bounded_generator_unit.sv
// Top level of the PCG64-DXSM bounded generator: sequencer around shared units.
// A raw draw takes four passes through the iterative 64x64 multiplier, then
// check and result. A bounded draw with a bound other than 2 adds a remainder
// for the threshold and another per accepted draw; each rejection repeats a draw.
// One item at a time; a new item is taken once all its results have gone.
// Reset (rst_n low, synchronous) restores increments, zeroes state and seeds.
module pcg64_dxsm_bounded_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  pcg_req_if.sink    in_req,
  pcg_res_if.source  out_res,
  input  logic       cfg_we,
  input  logic [pcg_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  pcg_pkg::state_t state_r, state_nxt;
  logic [63:0] inc_hi_r, inc_lo_r, s_hi_r, s_lo_r;
  logic [63:0] n_lo_r, n_hi_r, h_r, r_r;
  logic [63:0] bound_r, thresh_r, first_r, val_r, val2_r;
  logic [1:0] action_r;
  logic err_r, phase_r;
  pcg_pkg::mul_req_t mreq;
  pcg_pkg::mul_rsp_t mrsp;
  pcg_pkg::div_req_t dreq;
  pcg_pkg::div_rsp_t drsp;
  logic accept, bad;
  logic [63:0] h1, h2;

  pcg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  pcg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign accept = in_req.valid && in_req.ready;
  assign bad = (in_req.action == pcg_pkg::ACT_UNUSED) ||
               (in_req.action == pcg_pkg::ACT_BOUNDED && in_req.bound == 64'd0) ||
               (in_req.action == pcg_pkg::ACT_CHOOSE && in_req.bound < 64'd2);
  assign h1 = s_hi_r ^ {32'd0, s_hi_r[63:32]};
  assign h2 = mrsp.prod[63:0] ^ {48'd0, mrsp.prod[63:48]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcg_pkg::ST_IDLE: begin
        if (accept) begin
          if (bad) state_nxt = pcg_pkg::ST_OUT2;
          else if (in_req.action == pcg_pkg::ACT_RAW ||
                   in_req.bound == 64'd2) state_nxt = pcg_pkg::ST_LCG_LO;
          else state_nxt = pcg_pkg::ST_THRESH;
        end
      end
      pcg_pkg::ST_THRESH: state_nxt = pcg_pkg::ST_WAIT_THRESH;
      pcg_pkg::ST_WAIT_THRESH: if (drsp.done) state_nxt = pcg_pkg::ST_LCG_LO;
      pcg_pkg::ST_LCG_LO: state_nxt = pcg_pkg::ST_WAIT_LCG_LO;
      pcg_pkg::ST_WAIT_LCG_LO: if (mrsp.done) state_nxt = pcg_pkg::ST_LCG_HI;
      pcg_pkg::ST_LCG_HI: state_nxt = pcg_pkg::ST_WAIT_LCG_HI;
      pcg_pkg::ST_WAIT_LCG_HI: if (mrsp.done) state_nxt = pcg_pkg::ST_PERM1;
      pcg_pkg::ST_PERM1: state_nxt = pcg_pkg::ST_WAIT_PERM1;
      pcg_pkg::ST_WAIT_PERM1: if (mrsp.done) state_nxt = pcg_pkg::ST_PERM2;
      pcg_pkg::ST_PERM2: state_nxt = pcg_pkg::ST_WAIT_PERM2;
      pcg_pkg::ST_WAIT_PERM2: if (mrsp.done) state_nxt = pcg_pkg::ST_CHECK;
      pcg_pkg::ST_CHECK: begin
        if (action_r == pcg_pkg::ACT_RAW || bound_r == 64'd2)
          state_nxt = pcg_pkg::ST_RESULT;
        else if (r_r < thresh_r) state_nxt = pcg_pkg::ST_LCG_LO;
        else state_nxt = pcg_pkg::ST_MOD;
      end
      pcg_pkg::ST_MOD: state_nxt = pcg_pkg::ST_WAIT_MOD;
      pcg_pkg::ST_WAIT_MOD: if (drsp.done) state_nxt = pcg_pkg::ST_RESULT;
      pcg_pkg::ST_RESULT: begin
        if (action_r != pcg_pkg::ACT_CHOOSE) state_nxt = pcg_pkg::ST_OUT2;
        else if (bound_r == 64'd2) state_nxt = pcg_pkg::ST_OUT1;
        else if (!phase_r) state_nxt = pcg_pkg::ST_LCG_LO;
        else if (val_r == first_r) state_nxt = pcg_pkg::ST_LCG_LO;
        else state_nxt = pcg_pkg::ST_OUT1;
      end
      pcg_pkg::ST_OUT1: if (out_res.ready) state_nxt = pcg_pkg::ST_OUT2;
      pcg_pkg::ST_OUT2: if (out_res.ready) state_nxt = pcg_pkg::ST_IDLE;
      default: state_nxt = pcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    dreq = '0;
    case (state_r)
      pcg_pkg::ST_THRESH: begin
        dreq.start = 1'b1;
        dreq.num = 64'd0 - bound_r;
        dreq.den = bound_r;
      end
      pcg_pkg::ST_LCG_LO: begin
        mreq.start = 1'b1;
        mreq.a = s_lo_r;
        mreq.b = pcg_pkg::DxsmMult;
      end
      pcg_pkg::ST_LCG_HI: begin
        mreq.start = 1'b1;
        mreq.a = s_hi_r;
        mreq.b = pcg_pkg::DxsmMult;
      end
      pcg_pkg::ST_PERM1: begin
        mreq.start = 1'b1;
        mreq.a = h1;
        mreq.b = pcg_pkg::DxsmMult;
      end
      pcg_pkg::ST_PERM2: begin
        mreq.start = 1'b1;
        mreq.a = h_r;
        mreq.b = s_lo_r | 64'd1;
      end
      pcg_pkg::ST_MOD: begin
        dreq.start = 1'b1;
        dreq.num = r_r;
        dreq.den = bound_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcg_pkg::ST_IDLE;
      inc_hi_r <= pcg_pkg::IncHighReset;
      inc_lo_r <= pcg_pkg::IncLowReset | 64'd1;
      s_hi_r <= '0;
      s_lo_r <= '0;
      first_r <= '0;
      err_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pcg_pkg::RegIncHigh: inc_hi_r <= cfg_data;
          pcg_pkg::RegIncLow: inc_lo_r <= cfg_data | 64'd1;
          pcg_pkg::RegSeedHigh: s_hi_r <= cfg_data;
          pcg_pkg::RegSeedLow: s_lo_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        pcg_pkg::ST_IDLE: if (accept) begin
          action_r <= in_req.action;
          bound_r <= in_req.bound;
          err_r <= bad;
          phase_r <= 1'b0;
          val2_r <= '0;
        end
        pcg_pkg::ST_WAIT_THRESH: if (drsp.done) thresh_r <= drsp.rem;
        pcg_pkg::ST_WAIT_LCG_LO: if (mrsp.done) begin
          n_lo_r <= mrsp.prod[63:0] + inc_lo_r;
          n_hi_r <= mrsp.prod[127:64] + inc_hi_r +
                    {63'd0, (mrsp.prod[63:0] + inc_lo_r) < mrsp.prod[63:0]};
        end
        pcg_pkg::ST_WAIT_LCG_HI: if (mrsp.done) n_hi_r <= n_hi_r + mrsp.prod[63:0];
        pcg_pkg::ST_WAIT_PERM1: if (mrsp.done) h_r <= h2;
        pcg_pkg::ST_WAIT_PERM2: if (mrsp.done) begin
          r_r <= mrsp.prod[63:0];
          s_hi_r <= n_hi_r;
          s_lo_r <= n_lo_r;
        end
        pcg_pkg::ST_CHECK: begin
          if (action_r == pcg_pkg::ACT_RAW) val_r <= r_r;
          else if (bound_r == 64'd2) val_r <= {63'd0, r_r[0]};
        end
        pcg_pkg::ST_WAIT_MOD: if (drsp.done) val_r <= drsp.rem;
        pcg_pkg::ST_RESULT: begin
          if (action_r == pcg_pkg::ACT_CHOOSE) begin
            if (bound_r == 64'd2) begin
              first_r <= val_r;
              val2_r <= {63'd0, ~val_r[0]};
            end else if (!phase_r) begin
              first_r <= val_r;
              phase_r <= 1'b1;
            end else begin
              val2_r <= val_r;
            end
          end else begin
            val2_r <= val_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_req.ready = (state_r == pcg_pkg::ST_IDLE);
  assign out_res.valid = (state_r == pcg_pkg::ST_OUT1) || (state_r == pcg_pkg::ST_OUT2);
  assign out_res.value = (state_r == pcg_pkg::ST_OUT1) ? first_r :
                         (err_r ? 64'd0 : val2_r);
  assign out_res.last = (state_r == pcg_pkg::ST_OUT2);
  assign out_res.error = (state_r == pcg_pkg::ST_OUT2) && err_r;

endmodule

### design/pcg_checker.sv
// Port-level checks for the generator, bound to the top level.
module pcg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_value,
  input logic out_last,
  input logic out_error
);

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_value == 64'd0 && out_last)
    else $error("error item carries a value");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while results pending");

  a_value_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled item changed");

  a_first_then_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("first choice not followed by final item");

endmodule

bind pcg64_dxsm_bounded_generator_unit pcg_checker u_pcg_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_req.ready),
  .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_value(out_res.value), .out_last(out_res.last), .out_error(out_res.error)
);

### verif/tb_pcg64_dxsm_bounded_generator_unit.sv
// Self-checking testbench for the PCG64-DXSM bounded generator unit.
module tb_pcg64_dxsm_bounded_generator_unit;

  localparam int CycleLimit = 3000000;

  typedef struct {
    logic [63:0] value;
    logic        last;
    logic        error;
  } draw_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pcg_pkg::CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_data;

  pcg_req_if in_req();
  pcg_res_if out_res();

  pcg64_dxsm_bounded_generator_unit uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_res(out_res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow generator
  logic [63:0] inc_hi, inc_lo;
  logic [127:0] lcg_state;
  logic [63:0] first_pick;

  draw_res_t expected_results[$];
  int mismatches;
  int results_seen;
  int items_sent;
  longint unsigned cycles;
  bit idle_enable;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_pcg64_dxsm_bounded_generator_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] next_draw();
    logic [63:0] h;
    logic [63:0] lo;
    lo = lcg_state[63:0];
    h = lcg_state[127:64];
    lcg_state = lcg_state * {64'd0, pcg_pkg::DxsmMult} + {inc_hi, inc_lo};
    h = h ^ (h >> 32);
    h = h * pcg_pkg::DxsmMult;
    h = h ^ (h >> 48);
    h = h * (lo | 64'd1);
    return h;
  endfunction

  function automatic logic [63:0] draw_under(logic [63:0] bound);
    logic [63:0] thresh;
    logic [63:0] r;
    thresh = (64'd0 - bound) % bound;
    r = next_draw();
    while (r < thresh) r = next_draw();
    return r % bound;
  endfunction

  function automatic void push_res(logic [63:0] v, logic l, logic e);
    draw_res_t r;
    r.value = v;
    r.last = l;
    r.error = e;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(pcg_pkg::action_t act, logic [63:0] bound);
    logic [63:0] second;
    case (act)
      pcg_pkg::ACT_RAW: push_res(next_draw(), 1'b1, 1'b0);
      pcg_pkg::ACT_BOUNDED: begin
        if (bound == 0) push_res(64'd0, 1'b1, 1'b1);
        else push_res(draw_under(bound), 1'b1, 1'b0);
      end
      pcg_pkg::ACT_CHOOSE: begin
        if (bound < 2) begin
          push_res(64'd0, 1'b1, 1'b1);
        end else begin
          if (bound == 2) begin
            first_pick = next_draw() & 64'd1;
            second = 64'd1 - first_pick;
          end else begin
            first_pick = draw_under(bound);
            do second = draw_under(bound); while (second == first_pick);
          end
          push_res(first_pick, 1'b0, 1'b0);
          push_res(second, 1'b1, 1'b0);
        end
      end
      default: push_res(64'd0, 1'b1, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic write_reg(logic [pcg_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pcg_pkg::RegIncHigh: inc_hi = data;
      pcg_pkg::RegIncLow: inc_lo = data | 64'd1;
      pcg_pkg::RegSeedHigh: lcg_state[127:64] = data;
      default: lcg_state[63:0] = data;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(pcg_pkg::action_t act, logic [63:0] bound);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.action <= act;
    in_req.bound <= bound;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predict_request(act, bound);
    items_sent++;
  endtask

  // result checker and receiver stalls
  initial begin
    int stall;
    draw_res_t want;
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_res.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13);
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      if (out_res.valid && out_res.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_res.value, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_res.value !== want.value)
            report_mismatch("value", out_res.value, want.value);
          if (out_res.last !== want.last)
            report_mismatch("last", {63'd0, out_res.last}, {63'd0, want.last});
          if (out_res.error !== want.error)
            report_mismatch("error", {63'd0, out_res.error}, {63'd0, want.error});
        end
      end
    end
  end

  task automatic drain();
    in_req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 4));
      1: return 64'($urandom_range(3, 1000));
      2: return 64'd1 << $urandom_range(1, 63);
      3: return (64'd1 << 63) + 64'($urandom_range(0, 1000));
      4: return ~64'd0 - 64'($urandom_range(0, 5));
      default: return rand64();
    endcase
  endfunction

  task automatic test_directed();
    send_request(pcg_pkg::ACT_RAW, 64'd0);
    send_request(pcg_pkg::ACT_RAW, ~64'd0);
    send_request(pcg_pkg::ACT_BOUNDED, 64'd0);
    send_request(pcg_pkg::ACT_BOUNDED, 64'd1);
    send_request(pcg_pkg::ACT_BOUNDED, 64'd7);
    send_request(pcg_pkg::ACT_BOUNDED, (64'd1 << 63) + 64'd1);
    send_request(pcg_pkg::ACT_BOUNDED, ~64'd0);
    send_request(pcg_pkg::ACT_CHOOSE, 64'd0);
    send_request(pcg_pkg::ACT_CHOOSE, 64'd1);
    send_request(pcg_pkg::ACT_CHOOSE, 64'd2);
    send_request(pcg_pkg::ACT_CHOOSE, 64'd3);
    send_request(pcg_pkg::ACT_CHOOSE, ~64'd0);
    send_request(pcg_pkg::ACT_UNUSED, 64'd5);
    send_request(pcg_pkg::ACT_UNUSED, 64'hAAAA_5555_AAAA_5555);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(pcg_pkg::RegIncHigh, 64'd0);
    write_reg(pcg_pkg::RegIncLow, 64'd0);
    write_reg(pcg_pkg::RegSeedHigh, ~64'd0);
    write_reg(pcg_pkg::RegSeedLow, ~64'd0);
    repeat (4) send_request(pcg_pkg::ACT_RAW, 64'd0);
    send_request(pcg_pkg::ACT_CHOOSE, 64'd2);
    drain();
    write_reg(pcg_pkg::RegIncHigh, ~64'd0);
    write_reg(pcg_pkg::RegIncLow, ~64'd0);
    write_reg(pcg_pkg::RegSeedHigh, 64'd0);
    write_reg(pcg_pkg::RegSeedLow, 64'd0);
    repeat (4) send_request(pcg_pkg::ACT_RAW, 64'd0);
    send_request(pcg_pkg::ACT_BOUNDED, 64'd10);
    drain();
  endtask

  task automatic test_random(int count);
    pcg_pkg::action_t act;
    for (int i = 0; i < count; i++) begin
      act = pcg_pkg::action_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
      send_request(act, act == pcg_pkg::ACT_RAW ? rand64() : pick_bound());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    test_random(20);
    drain();
  endtask

  task automatic test_reseed_random();
    for (int p = 0; p < 3; p++) begin
      write_reg(pcg_pkg::RegIncHigh, rand64());
      write_reg(pcg_pkg::RegIncLow, rand64());
      write_reg(pcg_pkg::RegSeedHigh, rand64());
      write_reg(pcg_pkg::RegSeedLow, rand64());
      test_random(220);
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_req.valid = 1'b0;
    in_req.action = pcg_pkg::ACT_RAW;
    in_req.bound = '0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    hold_off = 1'b0;
    idle_enable = 1'b1;
    inc_hi = pcg_pkg::IncHighReset;
    inc_lo = pcg_pkg::IncLowReset | 64'd1;
    lcg_state = '0;
    first_pick = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_reseed_random();
    // last stretch without idling
    idle_enable = 1'b0;
    test_random(120);
    drain();

    $display("covered %0d requests, %0d results checked, all actions and bound edges",
             items_sent, results_seen);
    $display("increments and seeds written at extremes and random values");
    if (mismatches == 0) begin
      $display("tb_pcg64_dxsm_bounded_generator_unit OK");
    end else begin
      $display("tb_pcg64_dxsm_bounded_generator_unit NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/pcg_pkg.sv
design/pcg_stream_if.sv
design/pcg_mul.sv
design/pcg_div.sv
design/pcg64_dxsm_bounded_generator_unit.sv
design/pcg_checker.sv
verif/tb_pcg64_dxsm_bounded_generator_unit.sv
